### src/utf8s_pkg.sv
// Shared types for the UTF-8 sanitizer: controller states, action kinds and
// the command and status bundles between controller and datapath.
// No dependencies.
package utf8s_pkg;

   localparam int ByteWidth = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   // What the byte at the scan position resolves to.
   typedef enum logic [1:0] {
      KIND_ASCII,
      KIND_SEQ,
      KIND_REPL,
      KIND_HOLD
   } kind_type;

   typedef struct packed {
      logic load;
      logic act;
      logic emit;
      logic adv;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic     at_end;
      kind_type kind;
      logic     last_emit;
      logic     stage_ok;
   } stat_type;

endpackage

### src/utf8s_if.sv
// Valid/ready channel interfaces for the request and response beats of the
// UTF-8 sanitizer. Depends on utf8s_pkg.
interface utf8s_req_if;
   logic                           valid;
   logic                           ready;
   logic [utf8s_pkg::ByteWidth-1:0] in_byte;
   logic                           string_end;

   modport source (output valid, output in_byte, output string_end, input ready);
   modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

interface utf8s_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [utf8s_pkg::ByteWidth-1:0] out_byte;
   logic                           run_last;
   logic                           output_done;

   modport source (output valid, output out_byte, output run_last, output output_done,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input output_done,
                 output ready);
endinterface

### src/utf8s_ctrl.sv
// Controller of the UTF-8 sanitizer: sequences load, scan, emit and flush.
// Depends on utf8s_pkg.
module utf8s_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  utf8s_pkg::stat_type stat,
   output utf8s_pkg::cmd_type  cmd
);

   utf8s_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= utf8s_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         utf8s_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = utf8s_pkg::ST_SCAN;
            end
         end
         utf8s_pkg::ST_SCAN: begin
            if (stat.at_end || stat.kind == utf8s_pkg::KIND_HOLD) begin
               state_in = utf8s_pkg::ST_FLUSH;
            end else begin
               cmd.act  = 1'b1;
               state_in = utf8s_pkg::ST_EMIT;
            end
         end
         utf8s_pkg::ST_EMIT: begin
            if (stat.stage_ok) begin
               cmd.emit = 1'b1;
               if (stat.last_emit) begin
                  cmd.adv  = 1'b1;
                  state_in = utf8s_pkg::ST_SCAN;
               end
            end
         end
         utf8s_pkg::ST_FLUSH: begin
            if (stat.stage_ok) begin
               cmd.flush = 1'b1;
               state_in  = utf8s_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = utf8s_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### src/utf8s_dpath.sv
// Datapath of the UTF-8 sanitizer: byte window, scan position, classifier,
// one-byte hold stage and the response register. Depends on utf8s_pkg.
module utf8s_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [utf8s_pkg::ByteWidth-1:0] in_byte,
   input  logic                            string_end,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [utf8s_pkg::ByteWidth-1:0] out_byte,
   output logic                            run_last,
   output logic                            output_done,
   input  utf8s_pkg::cmd_type              cmd,
   output utf8s_pkg::stat_type             stat
);

   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChDel   = 8'h7F;
   localparam logic [7:0] ReplB0  = 8'hEF;
   localparam logic [7:0] ReplB1  = 8'hBF;
   localparam logic [7:0] ReplB2  = 8'hBD;

   function automatic logic [7:0] ascii_map(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c < ChSpace) begin
         if (!(c == ChTab || c == ChLf || c == ChCr)) r = ChSpace;
      end else if (c == ChDel) begin
         r = ChSpace;
      end
      return r;
   endfunction

   function automatic logic [2:0] seq_length(input logic [7:0] c);
      logic [2:0] r;
      r = 3'd0;
      if (c inside {[8'hC2:8'hDF]}) r = 3'd2;
      else if (c inside {[8'hE0:8'hEF]}) r = 3'd3;
      else if (c inside {[8'hF0:8'hF4]}) r = 3'd4;
      return r;
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return (b & 8'hC0) == 8'h80;
   endfunction

   function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
      logic r;
      case (lead)
         8'hE0:   r = b inside {[8'hA0:8'hBF]};
         8'hED:   r = b inside {[8'h80:8'h9F]};
         8'hF0:   r = b inside {[8'h90:8'hBF]};
         8'hF4:   r = b inside {[8'h80:8'h8F]};
         default: r = is_cont(b);
      endcase
      return r;
   endfunction

   // Byte window: pending bytes followed by the newly accepted byte.
   logic [7:0] buf_ff [4];
   logic [7:0] buf_in [4];
   logic [2:0] n_ff, n_in;
   logic [2:0] pos_ff, pos_in;
   logic [1:0] pend_ff, pend_in;
   logic       end_ff, end_in;
   utf8s_pkg::kind_type kind_ff, kind_in;
   logic [2:0] len_ff, len_in;
   logic [1:0] cnt_ff, cnt_in;

   logic [7:0] stage_byte_ff, stage_byte_in;
   logic       stage_vld_ff, stage_vld_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_done_ff, out_done_in;
   logic       out_vld_ff, out_vld_in;

   // Classifier signals.
   logic [7:0] c, b1, b2, b3, new_byte;
   logic [2:0] idx1, idx2, idx3, idx_emit, avail, len_c;
   logic       ok, out_free;
   utf8s_pkg::kind_type kind_c;

   always_comb begin
      idx1  = pos_ff + 3'd1;
      idx2  = pos_ff + 3'd2;
      idx3  = pos_ff + 3'd3;
      c     = buf_ff[pos_ff[1:0]];
      b1    = buf_ff[idx1[1:0]];
      b2    = buf_ff[idx2[1:0]];
      b3    = buf_ff[idx3[1:0]];
      avail = n_ff - pos_ff;
      len_c = seq_length(c);
      ok    = (len_c != 3'd0);
      if (ok && len_c > 3'd1 && avail > 3'd1) ok = second_ok(c, b1);
      if (ok && len_c > 3'd2 && avail > 3'd2) ok = is_cont(b2);
      if (ok && len_c > 3'd3 && avail > 3'd3) ok = is_cont(b3);
      if (c <= ChDel) kind_c = utf8s_pkg::KIND_ASCII;
      else if (ok && avail >= len_c) kind_c = utf8s_pkg::KIND_SEQ;
      else if (ok && !end_ff) kind_c = utf8s_pkg::KIND_HOLD;
      else kind_c = utf8s_pkg::KIND_REPL;
   end

   // Byte produced by the current action at emit index cnt_ff.
   always_comb begin
      idx_emit = pos_ff + {1'b0, cnt_ff};
      case (kind_ff)
         utf8s_pkg::KIND_ASCII: new_byte = ascii_map(buf_ff[pos_ff[1:0]]);
         utf8s_pkg::KIND_SEQ:   new_byte = buf_ff[idx_emit[1:0]];
         utf8s_pkg::KIND_REPL: begin
            case (cnt_ff)
               2'd0:    new_byte = ReplB0;
               2'd1:    new_byte = ReplB1;
               default: new_byte = ReplB2;
            endcase
         end
         default:               new_byte = ChSpace;
      endcase
   end

   assign out_free       = !out_vld_ff || rsp_ready;
   assign stat.at_end    = (pos_ff == n_ff);
   assign stat.kind      = kind_c;
   assign stat.last_emit = ({1'b0, cnt_ff} == len_ff - 3'd1);
   assign stat.stage_ok  = !stage_vld_ff || out_free;

   always_comb begin
      int k;
      logic [2:0] src;
      src           = 3'd0;
      buf_in        = buf_ff;
      n_in          = n_ff;
      pos_in        = pos_ff;
      pend_in       = pend_ff;
      end_in        = end_ff;
      kind_in       = kind_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      stage_byte_in = stage_byte_ff;
      stage_vld_in  = stage_vld_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      out_vld_in    = out_vld_ff && !rsp_ready;

      if (cmd.load) begin
         buf_in[pend_ff] = in_byte;
         n_in            = {1'b0, pend_ff} + 3'd1;
         pos_in          = 3'd0;
         end_in          = string_end;
      end
      if (cmd.act) begin
         kind_in = kind_c;
         cnt_in  = 2'd0;
         case (kind_c)
            utf8s_pkg::KIND_SEQ:  len_in = len_c;
            utf8s_pkg::KIND_REPL: len_in = 3'd3;
            default:              len_in = 3'd1;
         endcase
      end
      if (cmd.emit) begin
         // The held byte is not the last one of the run, since another follows.
         if (stage_vld_ff) begin
            out_byte_in = stage_byte_ff;
            out_last_in = 1'b0;
            out_done_in = 1'b0;
            out_vld_in  = 1'b1;
         end
         stage_byte_in = new_byte;
         stage_vld_in  = 1'b1;
         cnt_in        = cnt_ff + 2'd1;
      end
      if (cmd.adv) begin
         pos_in = (kind_ff == utf8s_pkg::KIND_SEQ) ? pos_ff + len_ff : pos_ff + 3'd1;
      end
      if (cmd.flush) begin
         if (stage_vld_ff) begin
            out_byte_in = stage_byte_ff;
            out_last_in = 1'b1;
            out_done_in = end_ff;
            out_vld_in  = 1'b1;
         end
         stage_vld_in = 1'b0;
         pend_in      = avail[1:0];
         for (k = 0; k < 3; k++) begin
            src             = pos_ff + 3'(k);
            buf_in[2'(k)]   = buf_ff[src[1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 2'd0;
         stage_vld_ff <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         stage_vld_ff <= stage_vld_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff        <= buf_in;
      n_ff          <= n_in;
      pos_ff        <= pos_in;
      end_ff        <= end_in;
      kind_ff       <= kind_in;
      len_ff        <= len_in;
      cnt_ff        <= cnt_in;
      stage_byte_ff <= stage_byte_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
      out_done_ff   <= out_done_in;
   end

   assign rsp_valid   = out_vld_ff;
   assign out_byte    = out_byte_ff;
   assign run_last    = out_last_ff;
   assign output_done = out_done_ff;

endmodule

### src/utf8_sanitizer_stream_core.sv
// Top level of the streaming UTF-8 sanitizer.
// Depends on utf8s_pkg, utf8s_if, utf8s_ctrl and utf8s_dpath.
//
// Usage: raw string bytes arrive as request beats on req_chan, one byte per
// beat, with string_end set on the last byte of a string. Sanitised bytes
// leave as response beats on rsp_chan. A request beat causes zero to twelve
// response beats; run_last marks the last response beat caused by a request
// beat, and output_done marks the final byte of the sanitised string.
// Valid UTF-8 prefixes that are still incomplete are held until the next
// request beat, so a request beat may cause no response at all.
//
// Timing: a request beat is taken in the idle state, then each action (one ASCII
// byte, one complete sequence or one replacement character) costs one scan
// state, then the emit state for its bytes. One more scan finds the window
// empty or a held prefix, and a final flush step releases the last byte and
// stores the pending bytes; only then can the block take the next beat. The
// controller walks the window one action at a time and emits one byte per
// cycle while the hold stage and the response register can take it.
//
// Reset (synchronous, active high) empties the pending bytes and the output
// valid flags. When the receiver stalls, the response register holds its beat
// and one further byte waits in a hold stage; the controller then pauses.
module utf8_sanitizer_stream_core (
   input logic        clock,
   input logic        reset,
   utf8s_req_if.sink   req_chan,
   utf8s_rsp_if.source rsp_chan
);

   // Command and status bundles between the controller and the datapath.
   utf8s_pkg::cmd_type  cmd;
   utf8s_pkg::stat_type stat;

   // The controller owns the request handshake; a beat is only taken while
   // it is idle, i.e. once every byte of the previous beat has been released.
   utf8s_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath owns the byte window, the classifier and the response
   // register, which drives the response channel directly.
   utf8s_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .in_byte     (req_chan.in_byte),
      .string_end  (req_chan.string_end),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .out_byte    (rsp_chan.out_byte),
      .run_last    (rsp_chan.run_last),
      .output_done (rsp_chan.output_done),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

### test/utf8_sanitizer_stream_core_tb.sv
// Self-checking testbench for utf8_sanitizer_stream_core: directed and random
// byte strings against a behavioural sanitiser written in the bench itself.
// Depends on utf8s_pkg, utf8s_if and the RTL of the block.
module utf8_sanitizer_stream_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [utf8s_pkg::ByteWidth-1:0] octet_type;

   // One raw byte waiting to be offered on the request channel. When
   // hold_for_drain is set the sender waits until every predicted response
   // beat has arrived before it offers this byte.
   typedef struct {
      octet_type in_byte;
      logic      string_end;
      logic      hold_for_drain;
   } raw_beat_type;

   // One predicted response beat.
   typedef struct {
      octet_type out_byte;
      logic      run_last;
      logic      output_done;
   } san_beat_type;

   // Shapes of the random stimulus chunks.
   typedef enum {
      CHUNK_ASCII,
      CHUNK_TWO,
      CHUNK_THREE,
      CHUNK_FOUR,
      CHUNK_BROKEN,
      CHUNK_CUT_AT_END,
      CHUNK_NOISE,
      CHUNK_BAD_LEAD
   } chunk_kind_type;

   localparam octet_type TAB    = 8'h09;
   localparam octet_type LF     = 8'h0A;
   localparam octet_type CR     = 8'h0D;
   localparam octet_type SPACE  = 8'h20;
   localparam octet_type DEL    = 8'h7F;
   localparam octet_type REPL_0 = 8'hEF;
   localparam octet_type REPL_1 = 8'hBF;
   localparam octet_type REPL_2 = 8'hBD;

   localparam int unsigned RandomTarget = 370;
   localparam int unsigned LongHold     = 400;
   // Worst case is roughly 370 beats x 12 responses x the longest random stall
   // each, plus sender gaps and the two long holds; this leaves a wide margin.
   localparam int unsigned CycleLimit   = 600000;

   logic clock;
   logic reset = 1'b1;

   utf8s_req_if req_chan ();
   utf8s_rsp_if rsp_chan ();

   utf8_sanitizer_stream_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Stimulus still to be offered, and sanitised beats still owed by the block.
   raw_beat_type raw_bytes[$];
   san_beat_type due_beats[$];

   // The bench's own copy of the bytes of an incomplete but valid prefix.
   octet_type   held_bytes[3];
   int unsigned held_count = 0;

   // Scratch queue filled by make_sequence for the stimulus generator.
   octet_type seq_bytes[$];

   int unsigned cycle_count = 0;
   int unsigned beats_in    = 0;
   int unsigned errors      = 0;
   logic        req_taken   = 1'b0;
   logic        rsp_taken   = 1'b0;
   int unsigned send_gap    = 0;
   int unsigned stall_left  = 0;
   int unsigned hold_left   = 0;
   logic        first_hold_done  = 1'b0;
   logic        second_hold_done = 1'b0;

   // The clock. The block inputs are set by the drivers while reset is high.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle length for either side: mostly none or short, now and then long.
   // Every fourth window of the cycle count runs with no random idling, so that
   // the block also sees stretches of back-to-back traffic.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (((cycle_count / 1500) % 4) == 3) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic void add_seq_byte(input octet_type b);
      seq_bytes = {seq_bytes, b};
   endfunction

   // Sanitises one raw byte against the held prefix and appends the
   // resulting beats to due_beats. The held bytes are re-examined from the
   // front each time, so a bad continuation or a string end in the middle of
   // a prefix turns only the lead into U+FFFD and rescans what follows it.
   function automatic void sanitise_beat(input octet_type raw, input logic str_end);
      octet_type    win[4];
      octet_type    produced[$];
      octet_type    lead;
      octet_type    nb;
      int unsigned  n;
      int unsigned  pos;
      int unsigned  k;
      int unsigned  len;
      int unsigned  avail;
      logic         ok;
      san_beat_type beat;

      n = held_count;
      for (k = 0; k < n; k++) win[k] = held_bytes[k];
      win[n] = raw;
      n++;
      pos = 0;

      while (pos < n) begin
         lead = win[pos];
         if (lead < SPACE) begin
            // Control bytes become a space, except tab, newline and return.
            produced = {produced, (lead == TAB || lead == LF || lead == CR) ? lead : SPACE};
            pos++;
         end else if (lead == DEL) begin
            produced = {produced, SPACE};
            pos++;
         end else if (lead < 8'h80) begin
            produced = {produced, lead};
            pos++;
         end else begin
            if (lead >= 8'hC2 && lead <= 8'hDF)      len = 2;
            else if (lead >= 8'hE0 && lead <= 8'hEF) len = 3;
            else if (lead >= 8'hF0 && lead <= 8'hF4) len = 4;
            else                                      len = 0;
            avail = n - pos;
            ok    = (len != 0);
            // Check only the bytes that have arrived so far.
            for (k = 1; ok && k < len && k < avail; k++) begin
               nb = win[pos + k];
               if (k == 1 && lead == 8'hE0)      ok = (nb >= 8'hA0 && nb <= 8'hBF);
               else if (k == 1 && lead == 8'hED) ok = (nb >= 8'h80 && nb <= 8'h9F);
               else if (k == 1 && lead == 8'hF0) ok = (nb >= 8'h90 && nb <= 8'hBF);
               else if (k == 1 && lead == 8'hF4) ok = (nb >= 8'h80 && nb <= 8'h8F);
               else                               ok = (nb[7:6] == 2'b10);
            end
            if (ok && avail >= len) begin
               for (k = 0; k < len; k++) produced = {produced, win[pos + k]};
               pos += len;
            end else if (ok && !str_end) begin
               // A valid prefix still waiting for its continuation bytes.
               break;
            end else begin
               produced = {produced, REPL_0, REPL_1, REPL_2};
               pos++;
            end
         end
      end

      held_count = n - pos;
      for (k = 0; k < held_count; k++) held_bytes[k] = win[pos + k];

      for (k = 0; k < produced.size(); k++) begin
         beat.out_byte    = produced[k];
         beat.run_last    = (k == produced.size() - 1);
         beat.output_done = beat.run_last && str_end;
         due_beats        = {due_beats, beat};
      end
   endfunction

   function automatic void push_raw(input octet_type b, input logic e, input logic drain);
      raw_beat_type item;
      item.in_byte        = b;
      item.string_end     = e;
      item.hold_for_drain = drain;
      raw_bytes           = {raw_bytes, item};
   endfunction

   // Fills seq_bytes with one well-formed sequence of the given length, the
   // second byte drawn from the narrowed range that its lead demands.
   function automatic void make_sequence(input int unsigned len);
      octet_type   lead;
      int unsigned k;
      seq_bytes.delete();
      if (len == 2)      lead = 8'($urandom_range(8'hC2, 8'hDF));
      else if (len == 3) lead = 8'($urandom_range(8'hE0, 8'hEF));
      else               lead = 8'($urandom_range(8'hF0, 8'hF4));
      add_seq_byte(lead);
      case (lead)
         8'hE0:   add_seq_byte(8'($urandom_range(8'hA0, 8'hBF)));
         8'hED:   add_seq_byte(8'($urandom_range(8'h80, 8'h9F)));
         8'hF0:   add_seq_byte(8'($urandom_range(8'h90, 8'hBF)));
         8'hF4:   add_seq_byte(8'($urandom_range(8'h80, 8'h8F)));
         default: add_seq_byte(8'($urandom_range(8'h80, 8'hBF)));
      endcase
      for (k = 2; k < len; k++) add_seq_byte(8'($urandom_range(8'h80, 8'hBF)));
   endfunction

   // Observation at the rising edge: accepted request beats feed the
   // sanitiser model, accepted response beats are checked against the
   // oldest owed beat. Request beats are handled first, though the block
   // cannot answer a beat in the cycle that it takes it.
   always @(posedge clock) begin : observe
      san_beat_type want;
      cycle_count++;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            req_taken = 1'b1;
            beats_in++;
            sanitise_beat(req_chan.in_byte, req_chan.string_end);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_taken = 1'b1;
            if (due_beats.size() == 0) begin
               if (errors < 10)
                  $display("cycle %0d: response beat %h/%b/%b with nothing owed",
                           cycle_count, rsp_chan.out_byte, rsp_chan.run_last,
                           rsp_chan.output_done);
               errors++;
            end else begin
               want = due_beats.pop_front();
               if (rsp_chan.out_byte !== want.out_byte || rsp_chan.run_last !== want.run_last
                   || rsp_chan.output_done !== want.output_done) begin
                  if (errors < 10)
                     $display("cycle %0d: byte/run_last/done expected %h/%b/%b, got %h/%b/%b",
                              cycle_count, want.out_byte, want.run_last, want.output_done,
                              rsp_chan.out_byte, rsp_chan.run_last, rsp_chan.output_done);
                  errors++;
               end
            end
         end
      end
   end

   // Request driver, at the falling edge. A beat stays offered until it is
   // taken; after that the sender may idle before offering the next byte.
   // Valid is assigned once per step from a local copy so that a beat that
   // follows straight on never sees valid drop and rise in the same step.
   always @(negedge clock) begin : drive_req
      raw_beat_type nxt;
      logic         nv;
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.in_byte    <= '0;
         req_chan.string_end <= 1'b0;
      end else begin
         nv = req_chan.valid;
         if (req_chan.valid && req_taken) begin
            nv       = 1'b0;
            send_gap = pick_gap();
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (raw_bytes.size() != 0
                         && !(raw_bytes[0].hold_for_drain && due_beats.size() != 0)) begin
               nxt = raw_bytes.pop_front();
               nv  = 1'b1;
               req_chan.in_byte    <= nxt.in_byte;
               req_chan.string_end <= nxt.string_end;
            end
         end
         req_chan.valid <= nv;
      end
   end

   // Response ready, at the falling edge. Short random stalls follow taken
   // beats; twice in the run the receiver holds off for a long stretch while
   // the sender keeps offering, so the block backs up and stalls its input.
   always @(negedge clock) begin : drive_rsp_ready
      logic r;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (!first_hold_done && beats_in >= 120) begin
            hold_left       = LongHold;
            first_hold_done = 1'b1;
         end
         if (!second_hold_done && beats_in >= 290) begin
            hold_left        = LongHold;
            second_hold_done = 1'b1;
         end
         if (rsp_taken) stall_left = pick_gap();
         if (hold_left > 0) begin
            hold_left--;
            r = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            r = 1'b0;
         end else begin
            r = 1'b1;
         end
         rsp_chan.ready <= r;
      end
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      wait (cycle_count >= CycleLimit);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      chunk_kind_type mix[10];
      chunk_kind_type kind;
      logic           want_drain;
      logic           mid_drain_done;
      logic           close_string;
      int unsigned    cut;
      int unsigned    k;

      mix = '{CHUNK_ASCII, CHUNK_ASCII, CHUNK_TWO, CHUNK_THREE, CHUNK_FOUR,
              CHUNK_BROKEN, CHUNK_CUT_AT_END, CHUNK_NOISE, CHUNK_BAD_LEAD,
              CHUNK_THREE};

      // Directed part. Control bytes, DEL and the kept whitespace; a well-
      // formed sequence of each length including the narrow second-byte
      // leads E0, ED and F4; a bad second byte after F0; overlong and out-of-
      // range leads; a stray continuation; then a valid prefix cut short by
      // the string end, and a one-byte string.
      push_raw(8'h00, 1'b0, 1'b0); push_raw(DEL, 1'b0, 1'b0);
      push_raw(CR, 1'b0, 1'b0);    push_raw(8'h41, 1'b0, 1'b0);
      push_raw(8'hC2, 1'b0, 1'b0); push_raw(8'hBF, 1'b0, 1'b0);
      push_raw(8'hE0, 1'b0, 1'b0); push_raw(8'hA0, 1'b0, 1'b0); push_raw(8'hBF, 1'b0, 1'b0);
      push_raw(8'hED, 1'b0, 1'b0); push_raw(8'h9F, 1'b0, 1'b0); push_raw(8'h80, 1'b0, 1'b0);
      push_raw(8'hF4, 1'b0, 1'b0); push_raw(8'h8F, 1'b0, 1'b0);
      push_raw(8'hBF, 1'b0, 1'b0); push_raw(8'hBF, 1'b0, 1'b0);
      push_raw(8'hF0, 1'b0, 1'b0); push_raw(8'h80, 1'b0, 1'b0);
      push_raw(8'hC0, 1'b0, 1'b0); push_raw(8'hFF, 1'b0, 1'b0);
      push_raw(8'hF1, 1'b0, 1'b0); push_raw(8'h80, 1'b0, 1'b0); push_raw(8'h80, 1'b1, 1'b0);
      push_raw(TAB, 1'b1, 1'b0);

      // Random part: mostly well-formed sequences with random content, the
      // rest broken prefixes, bad leads and plain noise. The first random
      // byte, and one further on, wait until the block has fully drained.
      want_drain     = 1'b1;
      mid_drain_done = 1'b0;
      while (raw_bytes.size() < RandomTarget) begin
         if (!mid_drain_done && raw_bytes.size() >= 200) begin
            want_drain     = 1'b1;
            mid_drain_done = 1'b1;
         end
         kind = mix[$urandom_range(0, 9)];
         seq_bytes.delete();
         case (kind)
            CHUNK_ASCII: add_seq_byte(8'($urandom_range(8'h00, 8'h7F)));
            CHUNK_TWO:   make_sequence(2);
            CHUNK_THREE: make_sequence(3);
            CHUNK_FOUR:  make_sequence(4);
            CHUNK_BROKEN, CHUNK_CUT_AT_END: begin
               make_sequence($urandom_range(2, 4));
               cut = $urandom_range(1, seq_bytes.size() - 1);
               while (seq_bytes.size() > cut) seq_bytes.delete(seq_bytes.size() - 1);
               if (kind == CHUNK_BROKEN) add_seq_byte(8'($urandom_range(8'h00, 8'hFF)));
            end
            CHUNK_NOISE: add_seq_byte(8'($urandom_range(8'h00, 8'hFF)));
            CHUNK_BAD_LEAD: begin
               case ($urandom_range(0, 2))
                  0:       add_seq_byte(8'($urandom_range(8'h80, 8'hBF)));
                  1:       add_seq_byte(8'($urandom_range(8'hC0, 8'hC1)));
                  default: add_seq_byte(8'($urandom_range(8'hF5, 8'hFF)));
               endcase
            end
            default: add_seq_byte(SPACE);
         endcase
         close_string = (kind == CHUNK_CUT_AT_END) || ($urandom_range(0, 7) == 0);
         for (k = 0; k < seq_bytes.size(); k++) begin
            push_raw(seq_bytes[k], close_string && (k == seq_bytes.size() - 1), want_drain);
            want_drain = 1'b0;
         end
      end
      // Close the last string so that nothing stays held in the block.
      push_raw(8'h2E, 1'b1, 1'b0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the last byte to be taken and every owed beat to arrive,
      // then keep watching so that any stray beat would show.
      while (raw_bytes.size() != 0 || req_chan.valid) @(posedge clock);
      while (due_beats.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
